### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, skipped while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dbsg_pkg.sv
// Package for the de Bruijn sequence generator: payload types, codes, defaults.
// No dependencies.
`default_nettype none
package dbsg_pkg;

  localparam int unsigned MaxSymbols = 16;
  localparam int unsigned MaxWord    = 8;
  localparam int unsigned StoreDepth = 8192;
  localparam int unsigned MaxPart    = 64;

  localparam logic [2:0] CfgAlphaLow  = 3'd0;
  localparam logic [2:0] CfgAlphaHigh = 3'd1;
  localparam logic [2:0] CfgSymCount  = 3'd2;
  localparam logic [2:0] CfgWordLen   = 3'd3;
  localparam logic [2:0] CfgPartSize  = 3'd4;

  localparam logic CmdGenerate = 1'b0;
  localparam logic CmdRead     = 1'b1;

  localparam logic [2:0] StSymbol   = 3'd0;
  localparam logic [2:0] StDone     = 3'd1;
  localparam logic [2:0] StTooLong  = 3'd2;
  localparam logic [2:0] StRange    = 3'd3;
  localparam logic [2:0] StNotGen   = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [12:0] part_idx;
  } dbsg_in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic [2:0] status;
  } dbsg_out_t;

endpackage
`default_nettype wire

### hw/rtl/de_bruijn_sequence_generator_unit.sv
// de Bruijn sequence generator B(k,n): FKM Lyndon-word sequencer and store.
// A generate command builds the sequence into the store, one symbol per cycle while a Lyndon word is emitted;
// a part read streams up to 64 symbols. Depends on dbsg_pkg, assert_macros.svh.
// A generate runs the size check, then stores the symbols of each Lyndon word
// whose length divides n, with one digit compare or copy per cycle for each
// Lyndon-word step, then runs the wrap and the part count. A part read streams
// one symbol per cycle while the output does not stall, through the single
// registered read port of the store. No clearing pass.
`default_nettype none
`include "assert_macros.svh"
module de_bruijn_sequence_generator_unit
  import dbsg_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = MaxSymbols,
  parameter int unsigned MAX_WORD    = MaxWord,
  parameter int unsigned STORE_DEPTH = StoreDepth,
  parameter int unsigned MAX_PART    = MaxPart
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire dbsg_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output dbsg_out_t      out_data_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned KW = $clog2(MAX_SYMBOLS);
  localparam int unsigned NW = $clog2(MAX_WORD + 1);
  localparam int unsigned PW = $clog2(MAX_PART + 1);
  localparam int unsigned PL = LW + PW;
  localparam int unsigned QW = LW + KW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_POW, S_EMIT, S_COPY, S_SCAN, S_WRAP, S_DIV, S_RDADR, S_RDDAT, S_SEND, S_OUT
  } state_e;

  logic [63:0] alo_q, ahi_q;
  logic [4:0]  kcfg_q;
  logic [3:0]  ncfg_q;
  logic [6:0]  pcfg_q;

  state_e state_q;
  logic [KW-1:0] lvl_q [MAX_WORD+1];
  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    rdat_q;
  logic [KW:0]   k_q;
  logic [NW-1:0] n_q, len_q, i_q;
  logic [QW-1:0] pow_q;
  logic [LW-1:0] pos_q, base_q, seqlen_q, wi_q, rd_q, end_q;
  logic [LW-1:0] ptot_q;
  logic [PW-1:0] plat_q;
  logic          gen_q;
  logic [LW-1:0] div_q;
  logic [PL-1:0] acc_q;
  dbsg_out_t     out_q;
  logic          ovalid_q;

  logic [KW:0] kc;
  logic [NW-1:0] nc;
  logic [PW-1:0] pc;
  always_comb begin
    kc = (kcfg_q == 5'd0) ? (KW+1)'(1) :
         ({27'd0, kcfg_q} > 32'(MAX_SYMBOLS)) ? (KW+1)'(MAX_SYMBOLS) : (KW+1)'(kcfg_q);
    nc = (ncfg_q == 4'd0) ? NW'(1) :
         ({28'd0, ncfg_q} > 32'(MAX_WORD)) ? NW'(MAX_WORD) : NW'(ncfg_q);
    pc = (pcfg_q == 7'd0) ? PW'(1) :
         ({25'd0, pcfg_q} > 32'(MAX_PART)) ? PW'(MAX_PART) : PW'(pcfg_q);
  end

  function automatic logic [7:0] sym_of(logic [KW-1:0] d, logic [63:0] lo, logic [63:0] hi);
    logic [3:0] dd;
    dd = 4'(d);
    return dd[3] ? hi[{dd[2:0], 3'b000} +: 8] : lo[{dd[2:0], 3'b000} +: 8];
  endfunction

  // len divides n when some multiple of len equals n
  logic divides;
  always_comb begin
    divides = 1'b0;
    for (int m = 1; m <= MAX_WORD; m++) begin
      if (32'(len_q) * 32'(m) == 32'(n_q)) divides = 1'b1;
    end
  end

  logic [KW-1:0] kmax;
  assign kmax = KW'(k_q - (KW+1)'(1));

  logic [LW-1:0] rd_nxt;
  logic          send_load;
  assign rd_nxt    = rd_q + LW'(1);
  assign send_load = (state_q == S_SEND) && (!ovalid_q || out_ready_i) && (rd_q != end_q);

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [AW-1:0] mem_ra;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_q[AW-1:0];
    mem_wd = sym_of(lvl_q[i_q], alo_q, ahi_q);
    mem_ra = rd_q[AW-1:0];
    case (state_q)
      S_EMIT:  mem_we = divides;
      S_WRAP:  mem_we = (wi_q != '0) && (wi_q != LW'(n_q));
      default: mem_we = 1'b0;
    endcase
    if (state_q == S_WRAP) mem_wd = rdat_q;
    if (send_load) mem_ra = rd_nxt[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdat_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alo_q <= 64'd12592;
      ahi_q <= '0;
      kcfg_q <= 5'd2;
      ncfg_q <= 4'd3;
      pcfg_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAlphaLow:  alo_q <= cfg_data_i;
        CfgAlphaHigh: ahi_q <= cfg_data_i;
        CfgSymCount:  kcfg_q <= cfg_data_i[4:0];
        CfgWordLen:   ncfg_q <= cfg_data_i[3:0];
        CfgPartSize:  pcfg_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int j = 0; j <= MAX_WORD; j++) lvl_q[j] <= '0;
      gen_q <= 1'b0;
      seqlen_q <= '0;
      ptot_q <= '0;
      plat_q <= '0;
      ovalid_q <= 1'b0;
      out_q <= '0;
      k_q <= '0; n_q <= '0; len_q <= '0; i_q <= '0;
      pow_q <= '0; pos_q <= '0; base_q <= '0; wi_q <= '0;
      rd_q <= '0; end_q <= '0; div_q <= '0; acc_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            if (in_data_i.cmd == CmdGenerate) begin
              k_q <= kc; n_q <= nc; i_q <= '0;
              pow_q <= QW'(1);
              state_q <= S_POW;
            end else if (!gen_q) begin
              out_q <= '{symbol: 8'd0, last: 1'b1, status: StNotGen};
              ovalid_q <= 1'b1; state_q <= S_OUT;
            end else if (32'(in_data_i.part_idx) >= 32'(ptot_q)) begin
              out_q <= '{symbol: 8'd0, last: 1'b1, status: StRange};
              ovalid_q <= 1'b1; state_q <= S_OUT;
            end else begin
              acc_q <= PL'(in_data_i.part_idx) * PL'(plat_q);
              state_q <= S_RDADR;
            end
          end
        end
        S_POW: begin
          if (i_q == n_q || pow_q > QW'(STORE_DEPTH)) begin
            if (pow_q + QW'(n_q) - QW'(1) > QW'(STORE_DEPTH)) begin
              gen_q <= 1'b0; seqlen_q <= '0; ptot_q <= '0; plat_q <= '0;
              out_q <= '{symbol: 8'd0, last: 1'b1, status: StTooLong};
              ovalid_q <= 1'b1; state_q <= S_OUT;
            end else begin
              for (int j = 0; j <= MAX_WORD; j++) lvl_q[j] <= '0;
              pos_q <= '0; len_q <= NW'(1); i_q <= NW'(1);
              state_q <= S_EMIT;
            end
          end else begin
            pow_q <= QW'(pow_q * QW'(k_q));
            i_q <= i_q + NW'(1);
          end
        end
        S_EMIT: begin
          if (!divides) begin
            i_q <= len_q + NW'(1); state_q <= S_COPY;
          end else begin
            pos_q <= pos_q + LW'(1);
            if (i_q == len_q) begin
              i_q <= len_q + NW'(1); state_q <= S_COPY;
            end else i_q <= i_q + NW'(1);
          end
        end
        S_COPY: begin
          if (i_q > n_q) begin
            len_q <= n_q; state_q <= S_SCAN;
          end else begin
            lvl_q[i_q] <= lvl_q[i_q - len_q];
            i_q <= i_q + NW'(1);
          end
        end
        S_SCAN: begin
          if (len_q == '0) begin
            base_q <= pos_q; wi_q <= '0; rd_q <= '0;
            state_q <= S_WRAP;
          end else if (lvl_q[len_q] == kmax) begin
            len_q <= len_q - NW'(1);
          end else begin
            lvl_q[len_q] <= lvl_q[len_q] + KW'(1);
            i_q <= NW'(1); state_q <= S_EMIT;
          end
        end
        S_WRAP: begin
          // wi_q = 0 primes the read; each wi_q from 1 to n - 1 stores one wrap symbol,
          // the read address wrapping at the Lyndon body length
          if (wi_q != '0) pos_q <= pos_q + LW'(1);
          if (wi_q == LW'(n_q)) begin
            seqlen_q <= pos_q; plat_q <= pc;
            div_q <= '0; acc_q <= PL'(0);
            state_q <= S_DIV;
          end else begin
            wi_q <= wi_q + LW'(1);
            rd_q <= (rd_nxt == base_q) ? '0 : rd_nxt;
          end
        end
        S_DIV: begin
          if (acc_q >= PL'(seqlen_q)) begin
            ptot_q <= div_q; gen_q <= 1'b1;
            out_q <= '{symbol: 8'd0, last: 1'b1, status: StDone};
            ovalid_q <= 1'b1; state_q <= S_OUT;
          end else begin
            acc_q <= acc_q + PL'(plat_q);
            div_q <= div_q + LW'(1);
          end
        end
        S_RDADR: begin
          rd_q <= acc_q[LW-1:0];
          end_q <= (acc_q + PL'(plat_q) > PL'(seqlen_q)) ? seqlen_q
                   : LW'(acc_q + PL'(plat_q));
          state_q <= S_RDDAT;
        end
        S_RDDAT: begin
          state_q <= S_SEND;
        end
        S_SEND: begin
          if (send_load) begin
            out_q <= '{symbol: rdat_q, last: (rd_nxt == end_q), status: StSymbol};
            ovalid_q <= 1'b1;
            rd_q <= rd_nxt;
          end else if (rd_q == end_q && out_ready_i) begin
            ovalid_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            ovalid_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o,
               !out_valid_o, "item accepted while a result waits")
  `ASSERT_IMPL(a_err_last, clk_i, rst_ni, out_valid_o && out_data_o.status != StSymbol,
               out_data_o.last && out_data_o.symbol == 8'd0, "status result not final")
  `ASSERT_NEXT(a_gen_len, clk_i, rst_ni, gen_q, seqlen_q != '0 || !gen_q,
               "generated with empty sequence")

endmodule
`default_nettype wire
